>>> rtl/core/lpm_pkg.sv
package lpm_pkg;

    // Field widths of the request and response
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int IFACE_W = 8;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;

    // Longest legal prefix; longer lengths are clamped to this
    localparam int MAX_LEN = 32;

    // Default build values for the top-level parameters
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int IFACE_BITS_DEF  = 8;

    // Request opcodes
    localparam logic [0:0] OP_WRITE  = 1'b0;
    localparam logic [0:0] OP_LOOKUP = 1'b1;

    // Incoming request
    typedef struct packed {
        logic [0:0]         opcode;
        logic [IDX_W-1:0]   entry_index;
        logic [ADDR_W-1:0]  net_addr;
        logic [LEN_W-1:0]   net_prefix_len;
        logic [IFACE_W-1:0] net_iface;
        logic [ADDR_W-1:0]  dest_addr;
    } t_lpm_req;

    // Lookup response
    typedef struct packed {
        logic [IFACE_W-1:0] out_iface;
        logic [LEN_W-1:0]   out_prefix_len;
        logic               matched;
    } t_lpm_rsp;

    // Lookup command handed from the front end to the scan engine
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [CNT_W-1:0]  route_count;
    } t_lpm_lookup;

endpackage

>>> rtl/core/lpm_ram.sv
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/lpm_scan.sv
module lpm_scan #(
    parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF,
    parameter int IFACE_BITS  = lpm_pkg::IFACE_BITS_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int EW = lpm_pkg::ADDR_W + lpm_pkg::LEN_W + IFACE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  lpm_pkg::t_lpm_lookup i_lookup,
    output logic                 o_idle,
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [EW-1:0]        i_rd_data,
    output logic                 o_rsp_valid,
    output lpm_pkg::t_lpm_rsp    o_rsp,
    input  logic                 i_rsp_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [AW-1:0]               r_idx;
    logic [AW-1:0]               r_last;
    logic                        r_pend;
    logic [lpm_pkg::ADDR_W-1:0]  r_dest;
    logic                        r_hit;
    logic [lpm_pkg::LEN_W-1:0]   r_best_len;
    logic [IFACE_BITS-1:0]       r_best_if;
    logic                        r_rsp_valid;
    lpm_pkg::t_lpm_rsp           r_rsp;

    logic [31:0]                 cnt32;
    logic [31:0]                 n32;
    logic [AW-1:0]               last_idx;
    logic [lpm_pkg::ADDR_W-1:0]  e_net;
    logic [lpm_pkg::LEN_W-1:0]   e_len;
    logic [IFACE_BITS-1:0]       e_if;
    logic [lpm_pkg::ADDR_W-1:0]  mask;
    logic                        match;
    logic                        better;
    logic                        rsp_free;

    // Entries searched: route_count clamped to the table depth
    assign cnt32    = 32'(i_lookup.route_count);
    assign n32      = (cnt32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt32;
    assign last_idx = AW'(n32 - 32'd1);

    // Entry layout: {network, length, interface}
    assign e_net = i_rd_data[EW-1 -: lpm_pkg::ADDR_W];
    assign e_len = i_rd_data[IFACE_BITS +: lpm_pkg::LEN_W];
    assign e_if  = i_rd_data[IFACE_BITS-1:0];

    // Prefix compare; a zero length gives an empty mask and always matches
    assign mask   = ~({lpm_pkg::ADDR_W{1'b1}} >> e_len);
    assign match  = ((r_dest ^ e_net) & mask) == '0;
    assign better = match && (!r_hit || (e_len > r_best_len));

    assign rsp_free = !r_rsp_valid || i_rsp_ready;

    // Sequencer, best-match tracking and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            // in S_DONE the response register is reloaded instead
            if (r_rsp_valid && i_rsp_ready && (r_state != S_DONE)) begin
                r_rsp_valid <= 1'b0;
            end

            // read data of the previous cycle is valid
            if (r_pend && better) begin
                r_hit      <= 1'b1;
                r_best_len <= e_len;
                r_best_if  <= e_if;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dest     <= i_lookup.dest;
                        r_idx      <= '0;
                        r_last     <= last_idx;
                        r_hit      <= 1'b0;
                        r_best_len <= '0;
                        r_best_if  <= '0;
                        r_state    <= (n32 == 32'd0) ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= 1'b1;
                    r_idx  <= r_idx + AW'(1);
                    if (r_idx == r_last) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_pend  <= 1'b0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (rsp_free) begin
                        r_rsp_valid          <= 1'b1;
                        r_rsp.out_iface      <= lpm_pkg::IFACE_W'(r_best_if);
                        r_rsp.out_prefix_len <= r_best_len;
                        r_rsp.matched        <= r_hit;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_rd_en     = (r_state == S_SCAN);
    assign o_rd_addr   = r_idx;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

>>> rtl/core/longest_prefix_match_lookup.sv
// IPv4 longest-prefix-match route table. A write request stores one route
// (network, prefix length clamped to 32, interface) at entry_index;
// indexes at or above TABLE_DEPTH are dropped. A lookup request scans
// entries 0 .. min(route_count, TABLE_DEPTH)-1 one per cycle through the
// single read port of the route RAM; the result then goes to the output
// register once that register is free. The longest matching prefix wins,
// the lowest index breaks ties, and a miss returns interface 0, length 0,
// matched 0. One request is in progress at a time; the next is accepted as
// soon as the previous result sits in the output register, even if that
// result has not been taken yet. Addresses use bit 31 as the first address
// bit. Entries must be written before a lookup searches them.
// route_count is written through i_cfg_we / i_cfg_data; the user must
// do so only while the block is idle, which the block does not enforce.
module longest_prefix_match_lookup #(
    parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF,
    parameter int IFACE_BITS  = lpm_pkg::IFACE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lpm_pkg::CNT_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lpm_pkg::t_lpm_req               i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lpm_pkg::t_lpm_rsp               o_out_rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW = lpm_pkg::ADDR_W + lpm_pkg::LEN_W + IFACE_BITS;

    logic [lpm_pkg::CNT_W-1:0] r_route_count;

    logic                      accept;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [lpm_pkg::LEN_W-1:0] wr_len;
    logic [EW-1:0]             wr_data;
    logic                      start;
    lpm_pkg::t_lpm_lookup      lookup;
    logic                      scan_idle;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [EW-1:0]             rd_data;

    // route_count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_count <= '0;
        end else if (i_cfg_we) begin
            r_route_count <= i_cfg_data;
        end
    end

    assign o_in_ready = scan_idle;
    assign accept     = i_in_valid && o_in_ready;

    // Route write: range check, length clamp, interface width
    assign wr_en   = accept && (i_in_req.opcode == lpm_pkg::OP_WRITE)
                     && (32'(i_in_req.entry_index) < 32'(TABLE_DEPTH));
    assign wr_addr = AW'(i_in_req.entry_index);
    assign wr_len  = (i_in_req.net_prefix_len > lpm_pkg::LEN_W'(lpm_pkg::MAX_LEN))
                     ? lpm_pkg::LEN_W'(lpm_pkg::MAX_LEN) : i_in_req.net_prefix_len;
    assign wr_data = {i_in_req.net_addr, wr_len, IFACE_BITS'(i_in_req.net_iface)};

    // Lookup launch
    assign start              = accept && (i_in_req.opcode == lpm_pkg::OP_LOOKUP);
    assign lookup.dest        = i_in_req.dest_addr;
    assign lookup.route_count = r_route_count;

    lpm_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_route_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lpm_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IFACE_BITS  (IFACE_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_lookup    (lookup),
        .o_idle      (scan_idle),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_rsp_valid (o_out_valid),
        .o_rsp       (o_out_rsp),
        .i_rsp_ready (i_out_ready)
    );

endmodule
